// ===== design/trfq_pkg.sv =====
package trfq_pkg;

   localparam int DEPTH_DEFAULT = 16;

   localparam int CMD_W     = 2;
   localparam int PAYLOAD_W = 32;
   localparam int TIME_W    = 48;
   localparam int SYNC_W    = 32;
   localparam int COUNT_W   = 5;
   localparam int LIMIT_W   = 5;
   localparam int TICKS_W   = 32;
   localparam int INDEX_W   = 3;

   localparam logic [CMD_W-1:0] CMD_ADD    = 2'd0;
   localparam logic [CMD_W-1:0] CMD_FETCH  = 2'd1;
   localparam logic [CMD_W-1:0] CMD_CLEAR  = 2'd2;
   localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;

   localparam logic [1:0] MODE_FIFO    = 2'd0;
   localparam logic [1:0] MODE_LATENCY = 2'd1;
   localparam logic [1:0] MODE_SAMPLE  = 2'd2;
   localparam logic [1:0] MODE_ORDERED = 2'd3;

   localparam logic [INDEX_W-1:0] REG_MODE   = 3'd0;
   localparam logic [INDEX_W-1:0] REG_LIMIT  = 3'd1;
   localparam logic [INDEX_W-1:0] REG_DROP   = 3'd2;
   localparam logic [INDEX_W-1:0] REG_LAT    = 3'd3;
   localparam logic [INDEX_W-1:0] REG_PERIOD = 3'd4;

   localparam logic [LIMIT_W-1:0] LIMIT_RESET      = 5'd16;
   localparam logic [TICKS_W-1:0] LATENCY_RESET    = 32'd1000;
   localparam logic [TICKS_W-1:0] PERIOD_RESET     = 32'd1;
   localparam logic [LIMIT_W-1:0] SAMPLE_MIN_LIMIT = 5'd2;
   localparam int                 SAMPLE_TOLERANCE = 10;

   typedef struct packed {
      logic write_tail;
      logic pop_drop;
      logic release_head;
      logic sort_step;
      logic sort_phase;
      logic sort_by_time;
      logic lrt_from_head;
      logic lrt_from_now;
      logic fft_from_now;
      logic exp_from_head;
      logic exp_next;
      logic div_start;
      logic clear_ctrs;
      logic set_rej;
      logic finish;
   } ctl_cmd_type;

   typedef struct packed {
      logic [CMD_W-1:0] command;
      logic [1:0]       mode;
      logic             rsp_busy;
      logic             cnt_zero;
      logic             cnt_ge2;
      logic             full;
      logic             over_limit;
      logic             stale_head;
      logic             expired;
      logic             fp_zero;
      logic             samp_drop;
      logic             samp_rel;
      logic             ord_drop;
      logic             ord_adv;
      logic             ord_rel;
      logic             div_done;
   } dp_status_type;

endpackage

// ===== design/trfq_ctrl.sv =====
module trfq_ctrl #(
   parameter int DEPTH = trfq_pkg::DEPTH_DEFAULT
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_tvalid,
   output logic                    req_tready,
   input  trfq_pkg::dp_status_type status,
   output trfq_pkg::ctl_cmd_type   cmd
);

   localparam int IW = $clog2(DEPTH);

   localparam logic [3:0] S_IDLE      = 4'd0;
   localparam logic [3:0] S_DISPATCH  = 4'd1;
   localparam logic [3:0] S_ADD_DROP  = 4'd2;
   localparam logic [3:0] S_SORT      = 4'd3;
   localparam logic [3:0] S_LAT_STALE = 4'd4;
   localparam logic [3:0] S_LAT_CHECK = 4'd5;
   localparam logic [3:0] S_DIV_WAIT  = 4'd6;
   localparam logic [3:0] S_SAMP      = 4'd7;
   localparam logic [3:0] S_ORD       = 4'd8;
   localparam logic [3:0] S_ORD_REL   = 4'd9;
   localparam logic [3:0] S_RELEASE   = 4'd10;
   localparam logic [3:0] S_DONE      = 4'd11;

   logic [3:0]    state_ff, state_in;
   logic [IW-1:0] pass_ff, pass_in;

   assign req_tready = (state_ff == S_IDLE) && !status.rsp_busy;

   always_comb begin
      state_in = state_ff;
      pass_in  = pass_ff;
      cmd      = '0;
      cmd.sort_phase   = pass_ff[0];
      cmd.sort_by_time = (status.mode == trfq_pkg::MODE_LATENCY);
      unique case (state_ff)
         S_IDLE: begin
            if (req_tvalid && req_tready) state_in = S_DISPATCH;
         end
         S_DISPATCH: begin
            pass_in  = '0;
            state_in = S_DONE;
            case (status.command)
               trfq_pkg::CMD_ADD: begin
                  if (status.full) begin
                     cmd.set_rej = 1'b1;
                  end else begin
                     cmd.write_tail = 1'b1;
                     state_in = S_ADD_DROP;
                  end
               end
               trfq_pkg::CMD_FETCH: begin
                  case (status.mode)
                     trfq_pkg::MODE_FIFO: begin
                        if (!status.cnt_zero) state_in = S_RELEASE;
                     end
                     trfq_pkg::MODE_LATENCY: begin
                        if (status.cnt_ge2) state_in = S_SORT;
                     end
                     trfq_pkg::MODE_SAMPLE: begin
                        if (!status.cnt_zero) begin
                           if (status.fp_zero) begin
                              cmd.fft_from_now = 1'b1;
                              state_in = S_RELEASE;
                           end else begin
                              cmd.div_start = 1'b1;
                              state_in = S_DIV_WAIT;
                           end
                        end
                     end
                     default: begin
                        if (!status.cnt_zero) state_in = S_SORT;
                     end
                  endcase
               end
               trfq_pkg::CMD_CLEAR: cmd.clear_ctrs = 1'b1;
               default: ;
            endcase
         end
         S_ADD_DROP: begin
            if (status.over_limit) cmd.pop_drop = 1'b1;
            else state_in = S_DONE;
         end
         S_SORT: begin
            cmd.sort_step = 1'b1;
            pass_in = pass_ff + 1'b1;
            if (pass_ff == IW'(DEPTH - 1)) begin
               state_in = (status.mode == trfq_pkg::MODE_LATENCY) ? S_LAT_STALE : S_ORD;
            end
         end
         S_LAT_STALE: begin
            if (status.stale_head) cmd.pop_drop = 1'b1;
            state_in = S_LAT_CHECK;
         end
         S_LAT_CHECK: begin
            if (!status.cnt_zero && status.expired) begin
               cmd.lrt_from_head = 1'b1;
               state_in = S_RELEASE;
            end else begin
               state_in = S_DONE;
            end
         end
         S_DIV_WAIT: begin
            if (status.div_done) state_in = S_SAMP;
         end
         S_SAMP: begin
            if (status.samp_drop) begin
               cmd.pop_drop = 1'b1;
            end else if (status.samp_rel) begin
               cmd.lrt_from_now = 1'b1;
               state_in = S_RELEASE;
            end else begin
               state_in = S_DONE;
            end
         end
         S_ORD: begin
            if (status.cnt_zero) begin
               state_in = S_DONE;
            end else if (status.ord_drop) begin
               cmd.pop_drop = 1'b1;
            end else begin
               cmd.exp_from_head = status.ord_adv;
               state_in = S_ORD_REL;
            end
         end
         S_ORD_REL: begin
            if (status.ord_rel) begin
               cmd.exp_next     = 1'b1;
               cmd.lrt_from_now = 1'b1;
               state_in = S_RELEASE;
            end else begin
               state_in = S_DONE;
            end
         end
         S_RELEASE: begin
            cmd.release_head = 1'b1;
            state_in = S_DONE;
         end
         S_DONE: begin
            cmd.finish = 1'b1;
            state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         pass_ff  <= '0;
      end else begin
         state_ff <= state_in;
         pass_ff  <= pass_in;
      end
   end

   a_no_add_when_full: assert property (@(posedge clock) disable iff (reset)
      cmd.write_tail |-> !status.full)
      else $error("tail write into a full store");

   a_release_needs_entry: assert property (@(posedge clock) disable iff (reset)
      cmd.release_head |-> !status.cnt_zero)
      else $error("release from an empty store");

   a_finish_output_free: assert property (@(posedge clock) disable iff (reset)
      cmd.finish |-> !status.rsp_busy)
      else $error("result beat overwritten while waiting");

endmodule

// ===== design/trfq_datapath.sv =====
module trfq_datapath #(
   parameter int DEPTH = trfq_pkg::DEPTH_DEFAULT
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_accept,
   input  logic [trfq_pkg::CMD_W-1:0]            req_command,
   input  logic [trfq_pkg::PAYLOAD_W-1:0]        req_payload,
   input  logic [trfq_pkg::TIME_W-1:0]           req_time,
   input  logic [trfq_pkg::SYNC_W-1:0]           req_sync,
   input  logic [trfq_pkg::TIME_W-1:0]           req_now,
   input  logic                                  csr_write,
   input  logic [trfq_pkg::INDEX_W-1:0]          csr_index,
   input  logic [trfq_pkg::TICKS_W-1:0]          csr_wdata,
   input  logic                                  rsp_ready,
   input  trfq_pkg::ctl_cmd_type                 cmd,
   output trfq_pkg::dp_status_type               status,
   output logic                                  rsp_valid,
   output logic                                  rsp_out_valid,
   output logic                                  rsp_rejected,
   output logic [trfq_pkg::PAYLOAD_W-1:0]        rsp_payload,
   output logic [trfq_pkg::TIME_W-1:0]           rsp_time,
   output logic [trfq_pkg::SYNC_W-1:0]           rsp_sync,
   output logic [trfq_pkg::COUNT_W-1:0]          rsp_drops,
   output logic [trfq_pkg::COUNT_W-1:0]          rsp_occupancy
);

   localparam int IW  = $clog2(DEPTH);
   localparam int CW  = $clog2(DEPTH + 1);
   localparam int LW  = (CW > trfq_pkg::LIMIT_W) ? CW : trfq_pkg::LIMIT_W;
   localparam int TW  = trfq_pkg::TIME_W;
   localparam int SW  = trfq_pkg::SYNC_W;
   localparam int PW  = trfq_pkg::PAYLOAD_W;
   localparam int KW  = trfq_pkg::TICKS_W;
   localparam int DCW = $clog2(TW + 1);

   // configuration
   logic [1:0]                     mode_ff;
   logic [trfq_pkg::LIMIT_W-1:0]   limit_ff;
   logic                           drop_ff;
   logic [KW-1:0]                  lat_ff;
   logic [KW-1:0]                  period_ff;

   // latched request
   logic [trfq_pkg::CMD_W-1:0]     rq_cmd_ff;
   logic [PW-1:0]                  rq_payload_ff;
   logic [TW-1:0]                  rq_time_ff;
   logic [SW-1:0]                  rq_sync_ff;
   logic [TW-1:0]                  rq_now_ff;

   // store
   logic [PW-1:0] slot_payload_ff [DEPTH];
   logic [PW-1:0] slot_payload_in [DEPTH];
   logic [TW-1:0] slot_time_ff    [DEPTH];
   logic [TW-1:0] slot_time_in    [DEPTH];
   logic [SW-1:0] slot_sync_ff    [DEPTH];
   logic [SW-1:0] slot_sync_in    [DEPTH];

   logic [CW-1:0] count_ff, count_in;
   logic [SW-1:0] fp_ff, fp_in;
   logic [SW-1:0] exp_ff, exp_in;
   logic [TW-1:0] lrt_ff, lrt_in;
   logic [TW-1:0] fft_ff, fft_in;

   // result beat
   logic                         rv_ff, rv_in;
   logic                         ov_ff, ov_in;
   logic                         rej_ff, rej_in;
   logic [PW-1:0]                op_ff, op_in;
   logic [TW-1:0]                ot_ff, ot_in;
   logic [SW-1:0]                os_ff, os_in;
   logic [trfq_pkg::COUNT_W-1:0] drops_ff, drops_in;
   logic [trfq_pkg::COUNT_W-1:0] occ_ff, occ_in;

   // divider
   logic [TW-1:0]  dq_ff, dq_in;
   logic [KW-1:0]  dr_ff, dr_in;
   logic [DCW-1:0] dcnt_ff, dcnt_in;
   logic           dbusy_ff, dbusy_in;

   logic [trfq_pkg::LIMIT_W-1:0] lim_eff;
   logic [KW-1:0]                per;
   logic [TW-1:0]                elapsed;
   logic [KW:0]                  trial;
   logic [SW:0]                  k_drop;
   logic [SW:0]                  k_rel;
   logic                         shift;
   logic                         swap;

   function automatic logic above(input logic [TW-1:0] q, input logic [KW-1:0] r,
                                  input logic [SW:0] k);
      logic [TW-1:0] kx;
      kx = TW'(k);
      return (q > kx) || ((q == kx) && (r != '0));
   endfunction

   assign lim_eff = ((mode_ff == trfq_pkg::MODE_SAMPLE) && (limit_ff < trfq_pkg::SAMPLE_MIN_LIMIT))
                    ? trfq_pkg::SAMPLE_MIN_LIMIT : limit_ff;
   assign per     = (period_ff == '0) ? KW'(1) : period_ff;
   assign elapsed = (rq_now_ff >= fft_ff) ? (rq_now_ff - fft_ff) : '0;
   assign k_drop  = {1'b0, fp_ff} + (SW+1)'(trfq_pkg::SAMPLE_TOLERANCE);
   assign k_rel   = {1'b0, fp_ff - SW'(1)};

   always_comb begin
      status.command    = rq_cmd_ff;
      status.mode       = mode_ff;
      status.rsp_busy   = rv_ff && !rsp_ready;
      status.cnt_zero   = (count_ff == '0);
      status.cnt_ge2    = (count_ff >= CW'(2));
      status.full       = (count_ff >= CW'(DEPTH));
      status.over_limit = drop_ff && (LW'(count_ff) > LW'(lim_eff));
      status.stale_head = (slot_time_ff[0] < lrt_ff) && (lrt_ff != '0);
      status.expired    = (({1'b0, slot_time_ff[0]} + (TW+1)'(lat_ff)) < {1'b0, rq_now_ff});
      status.fp_zero    = (fp_ff == '0);
      status.samp_drop  = status.cnt_ge2 && above(dq_ff, dr_ff, k_drop);
      status.samp_rel   = !status.cnt_zero && (status.fp_zero || above(dq_ff, dr_ff, k_rel));
      status.ord_drop   = status.expired || (slot_sync_ff[0] < exp_ff);
      status.ord_adv    = (slot_sync_ff[0] > exp_ff) &&
                          ({1'b0, rq_now_ff} > ({1'b0, lrt_ff} + (TW+1)'(lat_ff)));
      status.ord_rel    = (slot_sync_ff[0] == exp_ff) || status.expired;
      status.div_done   = !dbusy_ff;
   end

   always_comb begin
      slot_payload_in = slot_payload_ff;
      slot_time_in    = slot_time_ff;
      slot_sync_in    = slot_sync_ff;
      count_in = count_ff;
      fp_in    = fp_ff;
      exp_in   = exp_ff;
      lrt_in   = lrt_ff;
      fft_in   = fft_ff;
      ov_in    = ov_ff;
      rej_in   = rej_ff;
      op_in    = op_ff;
      ot_in    = ot_ff;
      os_in    = os_ff;
      drops_in = drops_ff;
      occ_in   = occ_ff;
      rv_in    = rv_ff;
      shift    = cmd.pop_drop || cmd.release_head;
      swap     = 1'b0;

      if (rv_ff && rsp_ready) rv_in = 1'b0;

      if (req_accept) begin
         ov_in    = 1'b0;
         rej_in   = 1'b0;
         op_in    = '0;
         ot_in    = '0;
         os_in    = '0;
         drops_in = '0;
      end

      if (cmd.write_tail) begin
         slot_payload_in[count_ff[IW-1:0]] = rq_payload_ff;
         slot_time_in[count_ff[IW-1:0]]    = rq_time_ff;
         slot_sync_in[count_ff[IW-1:0]]    = rq_sync_ff;
         count_in = count_ff + 1'b1;
      end

      if (cmd.release_head) begin
         ov_in = 1'b1;
         op_in = slot_payload_ff[0];
         ot_in = slot_time_ff[0];
         os_in = slot_sync_ff[0];
      end

      if (cmd.pop_drop) drops_in = drops_ff + 1'b1;

      if (shift) begin
         for (int i = 0; i < DEPTH - 1; i++) begin
            slot_payload_in[i] = slot_payload_ff[i+1];
            slot_time_in[i]    = slot_time_ff[i+1];
            slot_sync_in[i]    = slot_sync_ff[i+1];
         end
         count_in = count_ff - 1'b1;
         fp_in    = fp_ff + 1'b1;
      end

      // one odd-even transposition pass, strict compare keeps it stable
      if (cmd.sort_step) begin
         for (int i = 0; i < DEPTH - 1; i++) begin
            swap = (i[0] == cmd.sort_phase) && (CW'(i + 1) < count_ff) &&
                   (cmd.sort_by_time ? (slot_time_ff[i] > slot_time_ff[i+1])
                                     : (slot_sync_ff[i] > slot_sync_ff[i+1]));
            if (swap) begin
               slot_payload_in[i]   = slot_payload_ff[i+1];
               slot_time_in[i]      = slot_time_ff[i+1];
               slot_sync_in[i]      = slot_sync_ff[i+1];
               slot_payload_in[i+1] = slot_payload_ff[i];
               slot_time_in[i+1]    = slot_time_ff[i];
               slot_sync_in[i+1]    = slot_sync_ff[i];
            end
         end
      end

      if (cmd.lrt_from_head) lrt_in = slot_time_ff[0];
      if (cmd.lrt_from_now)  lrt_in = rq_now_ff;
      if (cmd.fft_from_now)  fft_in = rq_now_ff;
      if (cmd.exp_from_head) exp_in = slot_sync_ff[0];
      if (cmd.exp_next)      exp_in = slot_sync_ff[0] + 1'b1;
      if (cmd.set_rej)       rej_in = 1'b1;

      if (cmd.clear_ctrs) begin
         count_in = '0;
         fp_in    = '0;
         exp_in   = '0;
         lrt_in   = '0;
         fft_in   = '0;
      end

      if (cmd.finish) begin
         rv_in  = 1'b1;
         occ_in = trfq_pkg::COUNT_W'(count_ff);
      end
   end

   // restoring divider, one quotient bit per cycle
   always_comb begin
      dq_in    = dq_ff;
      dr_in    = dr_ff;
      dcnt_in  = dcnt_ff;
      dbusy_in = dbusy_ff;
      trial    = {dr_ff, dq_ff[TW-1]};
      if (cmd.div_start) begin
         dq_in    = elapsed;
         dr_in    = '0;
         dcnt_in  = DCW'(TW);
         dbusy_in = 1'b1;
      end else if (dbusy_ff) begin
         if (trial >= {1'b0, per}) begin
            dr_in = KW'(trial - {1'b0, per});
            dq_in = {dq_ff[TW-2:0], 1'b1};
         end else begin
            dr_in = trial[KW-1:0];
            dq_in = {dq_ff[TW-2:0], 1'b0};
         end
         dcnt_in  = dcnt_ff - 1'b1;
         dbusy_in = (dcnt_ff != DCW'(1));
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff   <= trfq_pkg::MODE_FIFO;
         limit_ff  <= trfq_pkg::LIMIT_RESET;
         drop_ff   <= 1'b0;
         lat_ff    <= trfq_pkg::LATENCY_RESET;
         period_ff <= trfq_pkg::PERIOD_RESET;
      end else if (csr_write) begin
         unique case (csr_index)
            trfq_pkg::REG_MODE:   mode_ff   <= csr_wdata[1:0];
            trfq_pkg::REG_LIMIT:  limit_ff  <= csr_wdata[trfq_pkg::LIMIT_W-1:0];
            trfq_pkg::REG_DROP:   drop_ff   <= csr_wdata[0];
            trfq_pkg::REG_LAT:    lat_ff    <= csr_wdata;
            trfq_pkg::REG_PERIOD: period_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         rq_cmd_ff     <= req_command;
         rq_payload_ff <= req_payload;
         rq_time_ff    <= req_time;
         rq_sync_ff    <= req_sync;
         rq_now_ff     <= req_now;
      end
      slot_payload_ff <= slot_payload_in;
      slot_time_ff    <= slot_time_in;
      slot_sync_ff    <= slot_sync_in;
      ov_ff    <= ov_in;
      rej_ff   <= rej_in;
      op_ff    <= op_in;
      ot_ff    <= ot_in;
      os_ff    <= os_in;
      drops_ff <= drops_in;
      occ_ff   <= occ_in;
      dq_ff    <= dq_in;
      dr_ff    <= dr_in;
      dcnt_ff  <= dcnt_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         fp_ff    <= '0;
         exp_ff   <= '0;
         lrt_ff   <= '0;
         fft_ff   <= '0;
         rv_ff    <= 1'b0;
         dbusy_ff <= 1'b0;
      end else begin
         count_ff <= count_in;
         fp_ff    <= fp_in;
         exp_ff   <= exp_in;
         lrt_ff   <= lrt_in;
         fft_ff   <= fft_in;
         rv_ff    <= rv_in;
         dbusy_ff <= dbusy_in;
      end
   end

   assign rsp_valid     = rv_ff;
   assign rsp_out_valid = ov_ff;
   assign rsp_rejected  = rej_ff;
   assign rsp_payload   = op_ff;
   assign rsp_time      = ot_ff;
   assign rsp_sync      = os_ff;
   assign rsp_drops     = drops_ff;
   assign rsp_occupancy = occ_ff;

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(DEPTH))
      else $error("occupancy beyond store depth");

   a_clear_empties: assert property (@(posedge clock) disable iff (reset)
      cmd.clear_ctrs |=> (count_ff == '0) && (fp_ff == '0))
      else $error("clear left entries behind");

   a_pop_needs_entry: assert property (@(posedge clock) disable iff (reset)
      cmd.pop_drop |-> (count_ff != '0))
      else $error("drop from an empty store");

endmodule

// ===== design/timed_reorder_frame_queue.sv =====
// Frame queue with four fetch policies: fifo, timestamp latency release,
// frame-rate sampling and sequence-ordered release with timeout.
// req channel: one beat per command (add, fetch, clear) with the frame
// fields and the current time; rsp channel: exactly one beat per command,
// giving the released frame (if any), drops, reject flag and occupancy.
// csr channel: register writes, taken every cycle; the user must write
// only while idle, which the block does not enforce. Commands are
// handled one at a time. Clear, reject, empty fifo fetch and unknown
// commands go straight to the rsp beat; add writes the tail and drops
// head entries over the limit. Latency and ordered fetch run an odd-even
// transposition sort of DEPTH passes, then may drop and release. Sampling
// fetch, once a frame has passed, runs a bit-serial divider of 48 steps
// first. The rsp beat shows in the same cycle that req can be taken again.
// The result sits in an output register; req is not taken again until
// that beat is gone or leaves in the same cycle, so a stalled rsp side
// holds off new commands. Reset empties the queue, clears the counters
// and loads the register defaults; the store contents are not cleared.
module timed_reorder_frame_queue #(
   parameter int DEPTH = trfq_pkg::DEPTH_DEFAULT
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_tvalid,
   output logic                          req_tready,
   input  logic [159:0]                  req_tdata,  // item_payload, item_time, item_sync, now_time
   input  logic [trfq_pkg::CMD_W-1:0]    req_tuser,  // command
   output logic                          rsp_tvalid,
   input  logic                          rsp_tready,
   output logic [127:0]                  rsp_tdata,  // out_payload, out_time, out_sync, drops,
                                                     // occupancy, zero fill
   output logic [1:0]                    rsp_tuser,  // out_valid, rejected
   input  logic                          csr_valid,
   output logic                          csr_ready,
   input  logic [trfq_pkg::INDEX_W-1:0]  csr_index,
   input  logic [trfq_pkg::TICKS_W-1:0]  csr_wdata
);

   trfq_pkg::ctl_cmd_type   cmd;
   trfq_pkg::dp_status_type status;

   logic                                 req_accept;
   logic                                 out_valid;
   logic                                 rejected;
   logic [trfq_pkg::PAYLOAD_W-1:0]       out_payload;
   logic [trfq_pkg::TIME_W-1:0]          out_time;
   logic [trfq_pkg::SYNC_W-1:0]          out_sync;
   logic [trfq_pkg::COUNT_W-1:0]         drops;
   logic [trfq_pkg::COUNT_W-1:0]         occupancy;

   assign csr_ready  = 1'b1;
   assign req_accept = req_tvalid && req_tready;

   trfq_ctrl #(.DEPTH(DEPTH)) u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .status     (status),
      .cmd        (cmd)
   );

   trfq_datapath #(.DEPTH(DEPTH)) u_datapath (
      .clock         (clock),
      .reset         (reset),
      .req_accept    (req_accept),
      .req_command   (req_tuser),
      .req_payload   (req_tdata[31:0]),
      .req_time      (req_tdata[79:32]),
      .req_sync      (req_tdata[111:80]),
      .req_now       (req_tdata[159:112]),
      .csr_write     (csr_valid && csr_ready),
      .csr_index     (csr_index),
      .csr_wdata     (csr_wdata),
      .rsp_ready     (rsp_tready),
      .cmd           (cmd),
      .status        (status),
      .rsp_valid     (rsp_tvalid),
      .rsp_out_valid (out_valid),
      .rsp_rejected  (rejected),
      .rsp_payload   (out_payload),
      .rsp_time      (out_time),
      .rsp_sync      (out_sync),
      .rsp_drops     (drops),
      .rsp_occupancy (occupancy)
   );

   assign rsp_tdata = {6'd0, occupancy, drops, out_sync, out_time, out_payload};
   assign rsp_tuser = {rejected, out_valid};

endmodule

// ===== sim/tb_timed_reorder_frame_queue.sv =====
`timescale 1ns / 100ps

module tb_timed_reorder_frame_queue;

   localparam int  STORE_DEPTH = 16;
   localparam int  CYCLE_LIMIT = 1500000;
   localparam int  SETTLE      = 100;

   typedef struct {
      bit [trfq_pkg::PAYLOAD_W-1:0] payload;
      bit [trfq_pkg::TIME_W-1:0]    stamp;
      bit [trfq_pkg::SYNC_W-1:0]    seq;
   } frame_type;

   typedef struct {
      bit                           released;
      bit [trfq_pkg::PAYLOAD_W-1:0] payload;
      bit [trfq_pkg::TIME_W-1:0]    stamp;
      bit [trfq_pkg::SYNC_W-1:0]    seq;
      bit [trfq_pkg::COUNT_W-1:0]   drops;
      bit                           rejected;
      bit [trfq_pkg::COUNT_W-1:0]   occupancy;
   } outcome_type;

   logic                           clock = 1'b0;
   logic                           reset = 1'b1;
   logic                           req_tvalid = 1'b0;
   logic                           req_tready;
   logic [159:0]                   req_tdata = '0;
   logic [trfq_pkg::CMD_W-1:0]     req_tuser = trfq_pkg::CMD_ADD;
   logic                           rsp_tvalid;
   logic                           rsp_tready = 1'b0;
   logic [127:0]                   rsp_tdata;
   logic [1:0]                     rsp_tuser;
   logic                           csr_valid = 1'b0;
   logic                           csr_ready;
   logic [trfq_pkg::INDEX_W-1:0]   csr_index = trfq_pkg::REG_MODE;
   logic [trfq_pkg::TICKS_W-1:0]   csr_wdata = '0;

   // queue predictor state and register copies
   frame_type                      held_frames[$];
   outcome_type                    pending_outcomes[$];
   bit [1:0]                       cur_mode;
   bit [trfq_pkg::LIMIT_W-1:0]     cur_limit;
   bit                             cur_drop;
   bit [trfq_pkg::TICKS_W-1:0]     cur_latency;
   bit [trfq_pkg::TICKS_W-1:0]     cur_period;
   bit [31:0]                      passed_count;
   bit [31:0]                      next_seq;
   bit [63:0]                      last_release;
   bit [63:0]                      first_fetch;

   int                   error_count = 0;
   int                   cycle_count = 0;
   bit                   no_idle = 1'b0;
   int                   hold_requests = 0;
   int                   hold_served = 0;
   int                   hold_left = 0;
   bit [47:0]            tick_now = 48'd5000;
   bit [31:0]            seq_gen = 0;

   timed_reorder_frame_queue i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("timeout after %0d cycles", cycle_count);
         $display("tb_timed_reorder_frame_queue NOT OK");
         $finish;
      end
   end

   // receiver: random stalls, long hold-off on request
   always @(posedge clock) begin
      if (hold_requests != hold_served) begin
         hold_served <= hold_served + 1;
         hold_left   <= 400;
         rsp_tready  <= 1'b0;
      end else if (hold_left > 0) begin
         hold_left  <= hold_left - 1;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= no_idle ? 1'b1 : ($urandom_range(99) >= 18);
      end
   end

   task automatic report_mismatch(string what, bit [63:0] got, bit [63:0] want);
      $display("mismatch %s: got %0h expected %0h at cycle %0d", what, got, want, cycle_count);
      error_count++;
   endtask

   // result checker
   always @(posedge clock) begin
      outcome_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (pending_outcomes.size() == 0) begin
            report_mismatch("unexpected beat", rsp_tdata[63:0], 0);
         end else begin
            want = pending_outcomes.pop_front();
            if (rsp_tuser[0] !== want.released)
               report_mismatch("out_valid", rsp_tuser[0], want.released);
            if (rsp_tdata[31:0] !== want.payload)
               report_mismatch("out_payload", rsp_tdata[31:0], want.payload);
            if (rsp_tdata[79:32] !== want.stamp)
               report_mismatch("out_time", rsp_tdata[79:32], want.stamp);
            if (rsp_tdata[111:80] !== want.seq)
               report_mismatch("out_sync", rsp_tdata[111:80], want.seq);
            if (rsp_tdata[116:112] !== want.drops)
               report_mismatch("drops", rsp_tdata[116:112], want.drops);
            if (rsp_tuser[1] !== want.rejected)
               report_mismatch("rejected", rsp_tuser[1], want.rejected);
            if (rsp_tdata[121:117] !== want.occupancy)
               report_mismatch("occupancy", rsp_tdata[121:117], want.occupancy);
            if (rsp_tdata[127:122] !== 6'd0)
               report_mismatch("tdata fill", rsp_tdata[127:122], 0);
         end
      end
   end

   function automatic bit is_stale(bit [47:0] stamp, bit [47:0] now);
      return ({16'd0, stamp} + {32'd0, cur_latency}) < {16'd0, now};
   endfunction

   function automatic bit ratio_above(bit [63:0] q, bit [63:0] r, bit [63:0] k);
      return q > k || (q == k && r > 0);
   endfunction

   function automatic void sort_frames(bit by_stamp);
      frame_type f;
      int        j;
      for (int i = 1; i < held_frames.size(); i++) begin
         f = held_frames[i];
         j = i;
         while (j > 0 && (by_stamp ? held_frames[j-1].stamp > f.stamp
                                   : held_frames[j-1].seq > f.seq)) begin
            held_frames[j] = held_frames[j-1];
            j--;
         end
         held_frames[j] = f;
      end
   endfunction

   function automatic void drop_head(ref outcome_type o);
      void'(held_frames.pop_front());
      passed_count++;
      o.drops++;
   endfunction

   function automatic outcome_type predict_queue(bit [1:0] cmd, frame_type item,
                                                 bit [47:0] now);
      outcome_type o;
      bit          rel;
      int          lim;
      bit [63:0]   per, el, q, r;
      o = '{default: '0};
      rel = 1'b0;
      if (cmd == trfq_pkg::CMD_ADD) begin
         if (held_frames.size() >= STORE_DEPTH) begin
            o.rejected = 1'b1;
         end else begin
            lim = cur_limit;
            if (cur_mode == trfq_pkg::MODE_SAMPLE && lim < trfq_pkg::SAMPLE_MIN_LIMIT)
               lim = trfq_pkg::SAMPLE_MIN_LIMIT;
            held_frames.insert(held_frames.size(), item);
            while (cur_drop && held_frames.size() > lim) drop_head(o);
         end
      end else if (cmd == trfq_pkg::CMD_FETCH) begin
         if (cur_mode == trfq_pkg::MODE_FIFO) begin
            rel = held_frames.size() > 0;
         end else if (cur_mode == trfq_pkg::MODE_LATENCY) begin
            if (held_frames.size() >= 2) begin
               sort_frames(1'b1);
               if (held_frames[0].stamp < last_release && last_release > 0) drop_head(o);
               if (held_frames.size() > 0 && is_stale(held_frames[0].stamp, now)) begin
                  rel = 1'b1;
                  last_release = held_frames[0].stamp;
               end
            end
         end else if (cur_mode == trfq_pkg::MODE_SAMPLE) begin
            if (held_frames.size() > 0) begin
               if (passed_count == 0) begin
                  rel = 1'b1;
                  first_fetch = now;
               end else begin
                  per = cur_period == 0 ? 64'd1 : {32'd0, cur_period};
                  el = now >= first_fetch ? now - first_fetch : 64'd0;
                  q = el / per;
                  r = el % per;
                  while (held_frames.size() >= 2 &&
                         ratio_above(q, r, {32'd0, passed_count} +
                                           trfq_pkg::SAMPLE_TOLERANCE))
                     drop_head(o);
                  if (held_frames.size() > 0 && (passed_count == 0 ||
                      ratio_above(q, r, {32'd0, passed_count} - 64'd1))) begin
                     rel = 1'b1;
                     last_release = now;
                  end
               end
            end
         end else begin
            if (held_frames.size() > 0) begin
               sort_frames(1'b0);
               while (held_frames.size() > 0) begin
                  if (is_stale(held_frames[0].stamp, now) || held_frames[0].seq < next_seq) begin
                     drop_head(o);
                     continue;
                  end
                  if (held_frames[0].seq > next_seq &&
                      {16'd0, now} > last_release + {32'd0, cur_latency})
                     next_seq = held_frames[0].seq;
                  break;
               end
               if (held_frames.size() > 0 && (held_frames[0].seq == next_seq ||
                   is_stale(held_frames[0].stamp, now))) begin
                  rel = 1'b1;
                  next_seq = held_frames[0].seq + 1;
                  last_release = now;
               end
            end
         end
         if (rel) begin
            o.released = 1'b1;
            o.payload  = held_frames[0].payload;
            o.stamp    = held_frames[0].stamp;
            o.seq      = held_frames[0].seq;
            void'(held_frames.pop_front());
            passed_count++;
         end
      end else if (cmd == trfq_pkg::CMD_CLEAR) begin
         held_frames.delete();
         passed_count = 0;
         next_seq = 0;
         last_release = 0;
         first_fetch = 0;
      end
      o.occupancy = trfq_pkg::COUNT_W'(held_frames.size());
      return o;
   endfunction

   // sends one command beat; tvalid stays high between back-to-back beats
   task automatic send_command(bit [1:0] cmd, bit [31:0] payload, bit [47:0] stamp,
                               bit [31:0] seq, bit [47:0] now);
      frame_type f;
      if (!no_idle && $urandom_range(99) < 18) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 6)) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= cmd;
      req_tdata  <= {now, seq, stamp, payload};
      do @(posedge clock); while (!req_tready);
      f = '{payload, stamp, seq};
      pending_outcomes.insert(pending_outcomes.size(), predict_queue(cmd, f, now));
   endtask

   task automatic wait_drained();
      req_tvalid <= 1'b0;
      do @(posedge clock); while (pending_outcomes.size() != 0);
      repeat (SETTLE) @(posedge clock);
   endtask

   task automatic write_reg(bit [trfq_pkg::INDEX_W-1:0] idx,
                            bit [trfq_pkg::TICKS_W-1:0] value);
      wait_drained();
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      case (idx)
         trfq_pkg::REG_MODE:   cur_mode = value[1:0];
         trfq_pkg::REG_LIMIT:  cur_limit = value[4:0];
         trfq_pkg::REG_DROP:   cur_drop = value[0];
         trfq_pkg::REG_LAT:    cur_latency = value;
         trfq_pkg::REG_PERIOD: cur_period = value;
         default: ;
      endcase
   endtask

   function automatic bit [47:0] any_stamp();
      return 48'({$urandom, $urandom});
   endfunction

   task automatic test_fifo_extremes();
      send_command(trfq_pkg::CMD_FETCH, 0, 0, 0, 0);
      send_command(trfq_pkg::CMD_ADD, 32'hFFFF_FFFF, 48'hFFFF_FFFF_FFFF, 32'hFFFF_FFFF,
                   48'hFFFF_FFFF_FFFF);
      send_command(trfq_pkg::CMD_ADD, 0, 0, 0, 0);
      send_command(trfq_pkg::CMD_UNUSED, 32'h1234, 48'h5678, 32'h9, 48'h1);
      send_command(trfq_pkg::CMD_FETCH, 0, 0, 0, 48'hFFFF_FFFF_FFFF);
      send_command(trfq_pkg::CMD_CLEAR, 0, 0, 0, 0);
      for (int i = 0; i < STORE_DEPTH + 1; i++)
         send_command(trfq_pkg::CMD_ADD, $urandom, any_stamp(), i, 0);
      send_command(trfq_pkg::CMD_FETCH, 0, 0, 0, 0);
      send_command(trfq_pkg::CMD_CLEAR, 0, 0, 0, 0);
   endtask

   task automatic test_drop_limits();
      write_reg(trfq_pkg::REG_DROP, 1);
      write_reg(trfq_pkg::REG_LIMIT, 0);
      send_command(trfq_pkg::CMD_ADD, 32'hA5, 48'd10, 32'd1, 48'd20);
      write_reg(trfq_pkg::REG_LIMIT, 1);
      send_command(trfq_pkg::CMD_ADD, 32'hA6, 48'd11, 32'd2, 48'd20);
      send_command(trfq_pkg::CMD_ADD, 32'hA7, 48'd12, 32'd3, 48'd20);
      write_reg(trfq_pkg::REG_MODE, trfq_pkg::MODE_SAMPLE);
      send_command(trfq_pkg::CMD_ADD, 32'hA8, 48'd13, 32'd4, 48'd20);
      write_reg(trfq_pkg::REG_PERIOD, 0);
      send_command(trfq_pkg::CMD_FETCH, 0, 0, 0, 48'd100);
      send_command(trfq_pkg::CMD_FETCH, 0, 0, 0, 48'd50);
      send_command(trfq_pkg::CMD_CLEAR, 0, 0, 0, 0);
      write_reg(trfq_pkg::REG_MODE, trfq_pkg::MODE_LATENCY);
      write_reg(trfq_pkg::REG_DROP, 0);
      write_reg(trfq_pkg::REG_LIMIT, 16);
      write_reg(trfq_pkg::REG_LAT, 10);
      send_command(trfq_pkg::CMD_ADD, 32'hB1, 48'd100, 32'd0, 48'd200);
      send_command(trfq_pkg::CMD_FETCH, 0, 0, 0, 48'd200);
      send_command(trfq_pkg::CMD_ADD, 32'hB2, 48'd50, 32'd0, 48'd200);
      send_command(trfq_pkg::CMD_ADD, 32'hB3, 48'd20, 32'd0, 48'd200);
      send_command(trfq_pkg::CMD_FETCH, 0, 0, 0, 48'd200);
      send_command(trfq_pkg::CMD_ADD, 32'hB4, 48'd10, 32'd0, 48'd200);
      send_command(trfq_pkg::CMD_FETCH, 0, 0, 0, 48'd200);
      send_command(trfq_pkg::CMD_CLEAR, 0, 0, 0, 0);
   endtask

   // well-formed traffic with time running forward, plus some noise
   task automatic run_traffic(int beats);
      bit [31:0] seq;
      bit [47:0] stamp;
      int        pick;
      for (int n = 0; n < beats; n++) begin
         pick = $urandom_range(99);
         tick_now += (cur_mode == trfq_pkg::MODE_SAMPLE) ? $urandom_range(4, 16)
                                                         : $urandom_range(0, 20);
         if ($urandom_range(99) < 3) tick_now = any_stamp();
         if (pick < 52) begin
            seq = seq_gen;
            if ($urandom_range(99) < 15) seq = seq_gen + $urandom_range(1, 3);
            else if ($urandom_range(99) < 5) seq = $urandom;
            else seq_gen++;
            stamp = tick_now - $urandom_range(0, 40);
            if ($urandom_range(99) < 4) stamp = any_stamp();
            send_command(trfq_pkg::CMD_ADD, $urandom, stamp, seq, tick_now);
         end else if (pick < 97) begin
            send_command(trfq_pkg::CMD_FETCH, $urandom, any_stamp(), $urandom, tick_now);
         end else if (pick < 99) begin
            seq_gen = 0;
            send_command(trfq_pkg::CMD_CLEAR, $urandom, any_stamp(), $urandom, tick_now);
         end else begin
            send_command(trfq_pkg::CMD_UNUSED, $urandom, any_stamp(), $urandom, tick_now);
         end
      end
   endtask

   task automatic test_fifo_random();
      write_reg(trfq_pkg::REG_MODE, trfq_pkg::MODE_FIFO);
      write_reg(trfq_pkg::REG_DROP, 1);
      write_reg(trfq_pkg::REG_LIMIT, 5);
      run_traffic(180);
      write_reg(trfq_pkg::REG_DROP, 0);
      run_traffic(120);
   endtask

   task automatic test_latency_random();
      write_reg(trfq_pkg::REG_MODE, trfq_pkg::MODE_LATENCY);
      write_reg(trfq_pkg::REG_LAT, 30);
      run_traffic(200);
      write_reg(trfq_pkg::REG_LAT, 32'hFFFF_FFFF);
      run_traffic(40);
      write_reg(trfq_pkg::REG_LAT, 1);
      run_traffic(60);
   endtask

   task automatic test_sample_random();
      write_reg(trfq_pkg::REG_MODE, trfq_pkg::MODE_SAMPLE);
      write_reg(trfq_pkg::REG_PERIOD, 10);
      send_command(trfq_pkg::CMD_CLEAR, 0, 0, 0, tick_now);
      run_traffic(200);
      write_reg(trfq_pkg::REG_PERIOD, 32'hFFFF_FFFF);
      run_traffic(40);
      write_reg(trfq_pkg::REG_PERIOD, 1);
      run_traffic(40);
   endtask

   task automatic test_ordered_random();
      write_reg(trfq_pkg::REG_MODE, trfq_pkg::MODE_ORDERED);
      write_reg(trfq_pkg::REG_LAT, 60);
      seq_gen = 0;
      send_command(trfq_pkg::CMD_CLEAR, 0, 0, 0, tick_now);
      run_traffic(220);
      write_reg(trfq_pkg::REG_DROP, 1);
      write_reg(trfq_pkg::REG_LIMIT, 8);
      run_traffic(80);
   endtask

   task automatic test_backpressure();
      write_reg(trfq_pkg::REG_MODE, trfq_pkg::MODE_FIFO);
      write_reg(trfq_pkg::REG_DROP, 0);
      write_reg(trfq_pkg::REG_LIMIT, 16);
      hold_requests++;
      run_traffic(60);
      no_idle = 1'b1;
      run_traffic(150);
      no_idle = 1'b0;
      wait_drained();
      run_traffic(40);
   endtask

   initial begin
      cur_mode = trfq_pkg::MODE_FIFO;
      cur_limit = trfq_pkg::LIMIT_RESET;
      cur_drop = 1'b0;
      cur_latency = trfq_pkg::LATENCY_RESET;
      cur_period = trfq_pkg::PERIOD_RESET;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_fifo_extremes();
      test_drop_limits();
      test_fifo_random();
      test_latency_random();
      test_sample_random();
      test_ordered_random();
      test_backpressure();
      wait_drained();
      if (error_count == 0) begin
         $display("tb_timed_reorder_frame_queue OK");
      end else begin
         $display("tb_timed_reorder_frame_queue NOT OK");
      end
      $finish;
   end

endmodule
